### sv/srtl_pkg.sv
// Shared types and constants for the sorted record table lookup block.
// Holds the channel word types, status codes and register indexes.
// No dependencies.
`default_nettype none

package srtl_pkg;

   // Table geometry defaults
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF    = 64;

   // Field widths
   localparam int NAME_W   = 64;
   localparam int AGE_W    = 7;
   localparam int ID_W     = 26;
   localparam int BAG_W    = 11;
   localparam int CLASS_W  = 2;
   localparam int STATUS_W = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ID      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ID      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BAGGAGE = 3'd3;

   // Register reset values
   localparam logic [AGE_W-1:0] MAX_AGE_RST     = 7'd110;
   localparam logic [ID_W-1:0]  MIN_ID_RST      = 26'd10000000;
   localparam logic [ID_W-1:0]  MAX_ID_RST      = 26'd65000000;
   localparam logic [BAG_W-1:0] MAX_BAGGAGE_RST = 11'd1600;

   // Request mode and seat class codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;
   localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

   typedef struct packed {
      logic               mode;
      logic [NAME_W-1:0]  name_key;
      logic [AGE_W-1:0]   age;
      logic [ID_W-1:0]    id_number;
      logic [BAG_W-1:0]   baggage;
      logic [CLASS_W-1:0] seat_class;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [AGE_W-1:0]    found_age;
      logic [ID_W-1:0]     found_id;
      logic [BAG_W-1:0]    found_baggage;
      logic [CLASS_W-1:0]  found_class;
   } rsp_type;

   // Record payload as kept in the table
   typedef struct packed {
      logic [CLASS_W-1:0] seat_class;
      logic [BAG_W-1:0]   baggage;
      logic [ID_W-1:0]    id_number;
      logic [AGE_W-1:0]   age;
   } payload_type;

endpackage

`default_nettype wire

### sv/srtl_cmp.sv
// Shared key comparator used by both the sort pass and the binary search.
// Depends on nothing but its parameter.
`default_nettype none

module srtl_cmp #(
   parameter int KEY_BITS = 64
) (
   input  wire logic [KEY_BITS-1:0] lhs,
   input  wire logic [KEY_BITS-1:0] rhs,
   output logic                     lhs_gt,
   output logic                     lhs_eq
);

   // Unsigned magnitude compare
   assign lhs_gt = (lhs > rhs);
   assign lhs_eq = (lhs == rhs);

endmodule

`default_nettype wire

### sv/srtl_store.sv
// Record table memory: one write port, one read port with registered data.
// Depends on srtl_pkg for the payload type.
`default_nettype none

module srtl_store #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 64,
   localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire logic [KEY_BITS-1:0]  wr_key,
   input  wire srtl_pkg::payload_type wr_payload,
   input  wire logic [IDX_W-1:0]     rd_addr,
   output logic [KEY_BITS-1:0]       rd_key,
   output srtl_pkg::payload_type     rd_payload
);

   logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
   srtl_pkg::payload_type pay_mem [TABLE_DEPTH];

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_payload;
      end
   end

   // Register read data every cycle
   always_ff @(posedge clock) begin
      rd_key     <= key_mem[rd_addr];
      rd_payload <= pay_mem[rd_addr];
   end

endmodule

`default_nettype wire

### sv/sorted_record_table_lookup.sv
// Sorted record table lookup: top level with the sequencer and limit registers.
// Depends on srtl_pkg, srtl_store and srtl_cmp.
//
// Usage:
//   req channel carries one request word (insert or lookup by name key).
//   rsp channel returns exactly one response word per request.
//   csr channel writes the limit registers (max age, id range, max baggage);
//   it is always ready; the user must write it only while the block is idle,
//   which the block itself does not enforce.
//   An insert completes in the accept cycle; its response is valid the next
//   cycle, so inserts stream at one per cycle while the receiver keeps up.
//   A lookup first re-sorts the table if records were added since the last
//   sort, through the single memory read port and the one shared comparator.
//   Each binary search probe reads the midpoint entry, then compares it with
//   the key, and a finish state then issues the response.
//   The block takes no new request while a lookup is in progress.
// Reset: the table empties (marked sorted) and the limits return to their
//   defaults; the table memory itself is not cleared.
// Stall: a response waits in the output register until taken; a request is
//   accepted only when that register is free or drains in the same cycle.
`default_nettype none

module sorted_record_table_lookup #(
   parameter int TABLE_DEPTH = srtl_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = srtl_pkg::KEY_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire srtl_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output srtl_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [srtl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [srtl_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_LDA,
      ST_SORT_LDW,
      ST_SORT_CMP,
      ST_SORT_WA,
      ST_LOOK,
      ST_LOOK_CMP,
      ST_FINISH
   } state_type;

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           sorted_ff, sorted_in;
   logic [IDX_W-1:0]               a_ff, a_in;
   logic [IDX_W-1:0]               b_ff, b_in;
   logic [IDX_W-1:0]               mid_ff, mid_in;
   logic [CNT_W-1:0]               lo_ff, lo_in;
   logic [CNT_W-1:0]               hi_ff, hi_in;
   logic [KEY_BITS-1:0]            cur_key_ff, cur_key_in;
   srtl_pkg::payload_type          cur_pay_ff, cur_pay_in;
   logic [KEY_BITS-1:0]            probe_ff, probe_in;
   srtl_pkg::rsp_type              res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   srtl_pkg::rsp_type              rsp_ff, rsp_in;
   logic [srtl_pkg::AGE_W-1:0]     max_age_ff, max_age_in;
   logic [srtl_pkg::ID_W-1:0]      min_id_ff, min_id_in;
   logic [srtl_pkg::ID_W-1:0]      max_id_ff, max_id_in;
   logic [srtl_pkg::BAG_W-1:0]     max_bag_ff, max_bag_in;

   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   logic [KEY_BITS-1:0]            wr_key;
   srtl_pkg::payload_type          wr_payload;
   logic [IDX_W-1:0]               rd_addr;
   logic [KEY_BITS-1:0]            rd_key;
   srtl_pkg::payload_type          rd_payload;

   logic [KEY_BITS-1:0]            cmp_lhs;
   logic                           cmp_gt;
   logic                           cmp_eq;

   logic                           slot_free;
   logic                           req_fire;
   logic                           rec_ok;
   logic                           tbl_full;
   logic [KEY_BITS-1:0]            req_key;
   srtl_pkg::payload_type          req_pay;
   logic [CNT_W:0]                 mid_sum;
   logic [IDX_W-1:0]               mid_calc;

   srtl_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_key     (wr_key),
      .wr_payload (wr_payload),
      .rd_addr    (rd_addr),
      .rd_key     (rd_key),
      .rd_payload (rd_payload)
   );

   // Sort compares the carried entry, search compares the probe key
   assign cmp_lhs = (state_ff == ST_LOOK_CMP) ? probe_ff : cur_key_ff;

   srtl_cmp #(
      .KEY_BITS (KEY_BITS)
   ) u_cmp (
      .lhs    (cmp_lhs),
      .rhs    (rd_key),
      .lhs_gt (cmp_gt),
      .lhs_eq (cmp_eq)
   );

   // Handshake
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Record check against the limits
   assign req_key = req_data.name_key[KEY_BITS-1:0];
   assign req_pay = '{seat_class: req_data.seat_class, baggage: req_data.baggage,
                      id_number: req_data.id_number, age: req_data.age};
   assign rec_ok = (req_data.age != '0) && (req_data.age <= max_age_ff)
                && (req_data.id_number >= min_id_ff) && (req_data.id_number <= max_id_ff)
                && (req_data.baggage <= max_bag_ff)
                && (req_data.seat_class != srtl_pkg::CLASS_INVALID);
   assign tbl_full = (count_ff >= CNT_W'(TABLE_DEPTH));

   // Search midpoint: floor((lo + hi_excl - 1) / 2)
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CNT_W{1'b0}}, 1'b1};
   assign mid_calc = mid_sum[IDX_W:1];

   // Memory port selection
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_W-1:0];
      wr_key     = req_key;
      wr_payload = req_pay;
      rd_addr    = '0;
      case (state_ff)
         ST_IDLE: begin
            wr_en = req_fire && (req_data.mode == srtl_pkg::MODE_INSERT)
                    && rec_ok && !tbl_full;
         end
         ST_SORT_LDA: begin
            rd_addr = a_ff;
         end
         ST_SORT_LDW: begin
            rd_addr = a_ff + IDX_W'(1);
         end
         ST_SORT_CMP: begin
            rd_addr    = b_ff + IDX_W'(1);
            wr_en      = cmp_gt;
            wr_addr    = b_ff;
            wr_key     = cur_key_ff;
            wr_payload = cur_pay_ff;
         end
         ST_SORT_WA: begin
            wr_en      = 1'b1;
            wr_addr    = a_ff;
            wr_key     = cur_key_ff;
            wr_payload = cur_pay_ff;
         end
         ST_LOOK: begin
            rd_addr = mid_calc;
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sorted_in    = sorted_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mid_in       = mid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cur_key_in   = cur_key_ff;
      cur_pay_in   = cur_pay_ff;
      probe_in     = probe_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      max_age_in   = max_age_ff;
      min_id_in    = min_id_ff;
      max_id_in    = max_id_ff;
      max_bag_in   = max_bag_ff;

      // Limit register writes
      if (csr_valid) begin
         case (csr_index)
            srtl_pkg::CSR_MAX_AGE:     max_age_in = csr_wdata[srtl_pkg::AGE_W-1:0];
            srtl_pkg::CSR_MIN_ID:      min_id_in  = csr_wdata[srtl_pkg::ID_W-1:0];
            srtl_pkg::CSR_MAX_ID:      max_id_in  = csr_wdata[srtl_pkg::ID_W-1:0];
            srtl_pkg::CSR_MAX_BAGGAGE: max_bag_in = csr_wdata[srtl_pkg::BAG_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.mode == srtl_pkg::MODE_INSERT) begin
                  // Insert answers at once
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (!rec_ok) begin
                     rsp_in.status = srtl_pkg::STATUS_INVALID;
                  end else if (tbl_full) begin
                     rsp_in.status = srtl_pkg::STATUS_FULL;
                  end else begin
                     rsp_in.status = srtl_pkg::STATUS_INSERTED;
                     count_in      = count_ff + CNT_W'(1);
                     sorted_in     = 1'b0;
                  end
               end else begin
                  probe_in = req_key;
                  lo_in    = '0;
                  hi_in    = count_ff;
                  a_in     = '0;
                  if (!sorted_ff && (count_ff >= CNT_W'(2))) begin
                     state_in = ST_SORT_LDA;
                  end else begin
                     sorted_in = 1'b1;
                     state_in  = ST_LOOK;
                  end
               end
            end
         end
         ST_SORT_LDA: begin
            state_in = ST_SORT_LDW;
         end
         ST_SORT_LDW: begin
            // Carry entry a, start the inner pass at a + 1
            cur_key_in = rd_key;
            cur_pay_in = rd_payload;
            b_in       = a_ff + IDX_W'(1);
            state_in   = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            // Swap when the carried key is greater: entry b takes the carried record, carry entry b on
            if (cmp_gt) begin
               cur_key_in = rd_key;
               cur_pay_in = rd_payload;
            end
            if (CNT_W'(b_ff) + CNT_W'(1) == count_ff) begin
               state_in = ST_SORT_WA;
            end else begin
               b_in = b_ff + IDX_W'(1);
            end
         end
         ST_SORT_WA: begin
            a_in = a_ff + IDX_W'(1);
            if (CNT_W'(a_ff) + CNT_W'(2) < count_ff) begin
               state_in = ST_SORT_LDA;
            end else begin
               sorted_in = 1'b1;
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               state_in = ST_LOOK_CMP;
            end else begin
               res_in        = '0;
               res_in.status = srtl_pkg::STATUS_NOT_FOUND;
               state_in      = ST_FINISH;
            end
         end
         ST_LOOK_CMP: begin
            if (cmp_eq) begin
               res_in.status        = srtl_pkg::STATUS_FOUND;
               res_in.found_age     = rd_payload.age;
               res_in.found_id      = rd_payload.id_number;
               res_in.found_baggage = rd_payload.baggage;
               res_in.found_class   = rd_payload.seat_class;
               state_in             = ST_FINISH;
            end else if (cmp_gt) begin
               lo_in    = CNT_W'(mid_ff) + CNT_W'(1);
               state_in = ST_LOOK;
            end else begin
               hi_in    = CNT_W'(mid_ff);
               state_in = ST_LOOK;
            end
         end
         ST_FINISH: begin
            // Hold the result until the output register frees up
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sorted_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
         max_age_ff   <= srtl_pkg::MAX_AGE_RST;
         min_id_ff    <= srtl_pkg::MIN_ID_RST;
         max_id_ff    <= srtl_pkg::MAX_ID_RST;
         max_bag_ff   <= srtl_pkg::MAX_BAGGAGE_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
         max_age_ff   <= max_age_in;
         min_id_ff    <= min_id_in;
         max_id_ff    <= max_id_in;
         max_bag_ff   <= max_bag_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      mid_ff     <= mid_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      cur_key_ff <= cur_key_in;
      cur_pay_ff <= cur_pay_in;
      probe_ff   <= probe_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire

### sv/srtl_checker.sv
// Port-level checks for the sorted record table lookup block, bound to the top.
// Depends on srtl_pkg for the word types and status codes.
`default_nettype none

module srtl_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire srtl_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire srtl_pkg::rsp_type rsp_data
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // An accepted insert answers in the next cycle
   a_insert_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode == srtl_pkg::MODE_INSERT) |=> rsp_valid)
      else $error("insert response missing");

   // A lookup keeps the block busy
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode == srtl_pkg::MODE_LOOKUP) |=> !req_ready)
      else $error("request taken during lookup");

   // Record fields are zero unless a record was found
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != srtl_pkg::STATUS_FOUND) |->
         (rsp_data.found_age == '0) && (rsp_data.found_id == '0)
         && (rsp_data.found_baggage == '0) && (rsp_data.found_class == '0))
      else $error("record fields set without a match");

   // Status is one of the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= srtl_pkg::STATUS_FULL))
      else $error("undefined status code");

endmodule

bind sorted_record_table_lookup srtl_checker u_srtl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
